>>> hw/rtl/rpm_pkg.sv
// Package: item kinds, register indexes and answer codes of the response pattern matcher.
package rpm_pkg;

  // Item kind carried in the input tuser field
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  // Configuration register indexes (byte address is 8 times the index)
  typedef enum logic [2:0] {
    REG_PATTERN_ONE   = 3'd0,
    REG_PATTERN_TWO   = 3'd1,
    REG_PATTERN_THREE = 3'd2,
    REG_PATTERN_FOUR  = 3'd3,
    REG_PATTERN_LENS  = 3'd4,
    REG_TIMEOUT       = 3'd5
  } reg_e;

  localparam int unsigned NUM_PATTERNS = 4;
  localparam int unsigned PAT_REG_W    = 64;
  localparam int unsigned LEN_W        = 4;
  localparam int unsigned ANSWER_W     = 3;
  localparam int unsigned HELD_OUT_W   = 8;
  localparam int unsigned TIMEOUT_W    = 32;

  localparam logic [ANSWER_W-1:0]   ANSWER_TIMEOUT  = 3'd0;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET   = 32'd1000;

endpackage

>>> hw/rtl/response_pattern_matcher.sv
// Top level: multi-pattern tail matcher over a received byte stream with tick timeout.
//
//  channel  | dir | handshake               | content
//  ---------+-----+-------------------------+-----------------------------------------
//  s_axis   | in  | tvalid/tready           | tuser = op, tdata = rx_byte
//  m_axis   | out | tvalid/tready           | tdata = answer, bytes_held (one per end)
//  apb      | in  | psel/penable/pready=1   | six registers at byte address 8*index
//
//  Each transaction lands in an input register and is evaluated from there
//  against the session state; the result register follows. One item per cycle is
//  sustained while the result register is free or being drained.
//  The input register holds while the result register is full and not taken.
//  Reset clears session state and loads register defaults; no clearing pass.
module response_pattern_matcher #(
  parameter int unsigned BUFFER_BYTES  = 256,
  parameter int unsigned PATTERN_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] answer, [10:3] bytes_held, [15:11] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import rpm_pkg::*;

  localparam int unsigned CNT_W  = $clog2(BUFFER_BYTES);
  localparam int unsigned HIST_W = 8 * PATTERN_BYTES;
  localparam int unsigned CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int unsigned SAT_W  = (CNT_W > HELD_OUT_W) ? CNT_W : HELD_OUT_W;
  localparam logic [CNT_W-1:0] HELD_MAX = CNT_W'(BUFFER_BYTES - 1);
  localparam logic [LEN_W-1:0] PB_LEN   = LEN_W'(PATTERN_BYTES);

  // configuration registers
  logic [PAT_REG_W-1:0] pat_q [NUM_PATTERNS];
  logic [15:0]          lens_q;
  logic [TIMEOUT_W-1:0] timeout_q;

  // input register
  logic       in_valid_q;
  logic [1:0] in_op_q;
  logic [7:0] in_rx_q;

  // session state
  logic [HIST_W-1:0]    hist_q, hist_d;
  logic [CNT_W-1:0]     held_q, held_d;
  logic [TIMEOUT_W-1:0] elapsed_q, elapsed_d;
  logic                 armed_q, armed_d;

  // result register
  logic                  out_valid_q;
  logic [ANSWER_W-1:0]   out_answer_q;
  logic [HELD_OUT_W-1:0] out_held_q;

  logic                  advance;
  logic                  res_valid;
  logic [ANSWER_W-1:0]   res_answer;
  logic [HELD_OUT_W-1:0] res_held;

  logic [HIST_W-1:0]     hist_shift;
  logic [CNT_W-1:0]      held_inc;
  logic [TIMEOUT_W-1:0]  elapsed_inc;
  logic [NUM_PATTERNS-1:0] hit;
  logic                  any_hit;
  logic [ANSWER_W-1:0]   hit_answer;
  logic [SAT_W-1:0]      held_ext, held_inc_ext;
  logic [HELD_OUT_W-1:0] held_sat, held_inc_sat;
  logic                  cfg_write;

  // ---------------------------------------------------------------------------
  // APB register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_PATTERNS; k++) begin
        pat_q[k] <= '0;
      end
      lens_q    <= '0;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (reg_e'(paddr[5:3]))
        REG_PATTERN_ONE:   pat_q[0]  <= pwdata;
        REG_PATTERN_TWO:   pat_q[1]  <= pwdata;
        REG_PATTERN_THREE: pat_q[2]  <= pwdata;
        REG_PATTERN_FOUR:  pat_q[3]  <= pwdata;
        REG_PATTERN_LENS:  lens_q    <= pwdata[15:0];
        REG_TIMEOUT:       timeout_q <= pwdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[5:3]))
      REG_PATTERN_ONE:   prdata = pat_q[0];
      REG_PATTERN_TWO:   prdata = pat_q[1];
      REG_PATTERN_THREE: prdata = pat_q[2];
      REG_PATTERN_FOUR:  prdata = pat_q[3];
      REG_PATTERN_LENS:  prdata = {48'd0, lens_q};
      REG_TIMEOUT:       prdata = {32'd0, timeout_q};
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register: advance when the result slot is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q <= s_axis_tuser;
      in_rx_q <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Shifted history: newest byte enters the top
  if (PATTERN_BYTES == 1) begin : g_hist_one
    assign hist_shift = in_rx_q;
  end else begin : g_hist_many
    assign hist_shift = {in_rx_q, hist_q[HIST_W-1:8]};
  end

  assign held_inc    = held_q + CNT_W'(1);
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TIMEOUT_W'(1);

  // Saturate the held count to the output field
  assign held_ext     = SAT_W'(held_q);
  assign held_inc_ext = SAT_W'(held_inc);
  assign held_sat     = (held_ext > SAT_W'(255)) ? 8'hFF : held_ext[HELD_OUT_W-1:0];
  assign held_inc_sat = (held_inc_ext > SAT_W'(255)) ? 8'hFF : held_inc_ext[HELD_OUT_W-1:0];

  // Compare every enabled pattern with the tail of the shifted history
  always_comb begin
    logic [LEN_W-1:0]  len_raw;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  shamt;
    logic [HIST_W-1:0] tail;
    logic              eq;
    for (int k = 0; k < NUM_PATTERNS; k++) begin
      len_raw = lens_q[LEN_W*k +: LEN_W];
      len     = (len_raw > PB_LEN) ? PB_LEN : len_raw;
      shamt   = PB_LEN - len;
      tail    = hist_shift >> {shamt, 3'b000};
      eq      = 1'b1;
      for (int j = 0; j < PATTERN_BYTES; j++) begin
        if ((LEN_W'(j) < len) && (tail[8*j +: 8] != pat_q[k][8*j +: 8])) begin
          eq = 1'b0;
        end
      end
      hit[k] = eq && (len != '0) && (CMP_W'(held_inc) >= CMP_W'(len));
    end
  end

  // Lowest-numbered hit wins
  always_comb begin
    any_hit    = |hit;
    hit_answer = ANSWER_TIMEOUT;
    for (int k = NUM_PATTERNS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        hit_answer = ANSWER_W'(k + 1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Session update and result decision
  always_comb begin
    hist_d     = hist_q;
    held_d     = held_q;
    elapsed_d  = elapsed_q;
    armed_d    = armed_q;
    res_valid  = 1'b0;
    res_answer = ANSWER_TIMEOUT;
    res_held   = held_sat;
    if (advance) begin
      case (in_op_q)
        OP_START: begin
          hist_d    = '0;
          held_d    = '0;
          elapsed_d = '0;
          armed_d   = 1'b1;
          if (timeout_q == '0) begin
            armed_d   = 1'b0;
            res_valid = 1'b1;
            res_held  = '0;
          end
        end
        OP_BYTE: begin
          if (armed_q && (held_q < HELD_MAX)) begin
            hist_d = hist_shift;
            held_d = held_inc;
            if (any_hit) begin
              armed_d    = 1'b0;
              res_valid  = 1'b1;
              res_answer = hit_answer;
              res_held   = held_inc_sat;
            end
          end
        end
        OP_TICK: begin
          if (armed_q) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= timeout_q) begin
              armed_d   = 1'b0;
              res_valid = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= '0;
      held_q    <= '0;
      elapsed_q <= '0;
      armed_q   <= 1'b0;
    end else begin
      hist_q    <= hist_d;
      held_q    <= held_d;
      elapsed_q <= elapsed_d;
      armed_q   <= armed_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load on a session end, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_answer_q <= res_answer;
      out_held_q   <= res_held;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_held_q, out_answer_q};

`ifndef SYNTHESIS
  // A session end always leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid |=> !armed_q)
    else $error("block still armed after a session end");

  // Held count never passes the buffer limit
  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q <= HELD_MAX)
    else $error("held count beyond buffer limit");

  // An idle block reports nothing for bytes or ticks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (advance && !armed_q && (in_op_q != OP_START)) |-> !res_valid)
    else $error("result from an idle block");

  // A result is never overwritten before it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && !m_axis_tready) |-> !res_valid)
    else $error("pending result overwritten");
`endif

endmodule

>>> bench/testbench.sv
// Self-checking bench for the response pattern matcher: directed cases, then random sessions.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rpm_pkg::*;

  // op code that the block ignores
  localparam logic [1:0] OP_UNUSED     = 2'd3;
  // bytes kept per session before the buffer counts as full
  localparam int unsigned HOLD_LIMIT    = 255;
  localparam int unsigned PAT_CHARS     = 8;
  // margin for the input and result registers to empty
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned PHASE_ITEMS   = 400;

  localparam logic [7:0]  CH_CR         = 8'h0D;
  localparam logic [7:0]  CH_LF         = 8'h0A;
  // "OK" CR LF, first character in the lowest byte
  localparam logic [63:0] RESP_OK       = 64'h0000_0000_0A0D_4B4F;

  typedef struct packed {
    logic [ANSWER_W-1:0]   answer;
    logic [HELD_OUT_W-1:0] held;
  } session_end_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
  logic [1:0]  s_axis_tuser = '0;   // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [2:0] answer, [10:3] bytes_held, [15:11] zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  // predicted block state and register copies
  logic [63:0] pattern_cfg [NUM_PATTERNS];
  logic [15:0] lens_cfg;
  logic [31:0] timeout_cfg;
  logic [63:0] hist_bytes;
  int unsigned held_bytes;
  logic [31:0] ticks_seen;
  bit          session_armed;

  session_end_t ends_q [$];
  logic [7:0]   inject_q [$];
  int unsigned  live_items;
  int unsigned  mismatches;
  int unsigned  quiet_cycles;
  int unsigned  src_gap_pct;
  int unsigned  sink_gap_pct;

  response_pattern_matcher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Count a mismatch, report the first few
  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endfunction

  // Advance the predicted session by one transaction; return 1 when a session ends
  function automatic bit step_session(input logic [1:0] op, input logic [7:0] rx,
                                      output session_end_t res);
    int unsigned len;
    logic [63:0] mask;
    logic [63:0] tail;
    res = '0;
    if (op == OP_START) begin
      hist_bytes = '0;
      held_bytes = 0;
      ticks_seen = '0;
      session_armed = 1'b1;
      if (timeout_cfg == '0) begin
        session_armed = 1'b0;
        res.answer = ANSWER_TIMEOUT;
        return 1'b1;
      end
      return 1'b0;
    end
    if (!session_armed) return 1'b0;
    if (op == OP_BYTE) begin
      if (held_bytes >= HOLD_LIMIT) return 1'b0;
      hist_bytes = {rx, hist_bytes[63:8]};
      held_bytes++;
      // lowest-numbered matching tail wins
      for (int k = 0; k < NUM_PATTERNS; k++) begin
        len = 32'(lens_cfg[LEN_W*k +: LEN_W]);
        if (len > PAT_CHARS) len = PAT_CHARS;
        if (len != 0 && held_bytes >= len) begin
          mask = (len == PAT_CHARS) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
          tail = hist_bytes >> (8 * (PAT_CHARS - len));
          if ((tail & mask) == (pattern_cfg[k] & mask)) begin
            session_armed = 1'b0;
            res.answer = ANSWER_W'(k + 1);
            res.held = HELD_OUT_W'(held_bytes);
            return 1'b1;
          end
        end
      end
      return 1'b0;
    end
    if (op == OP_TICK) begin
      if (ticks_seen != '1) ticks_seen++;
      if (ticks_seen >= timeout_cfg) begin
        session_armed = 1'b0;
        res.answer = ANSWER_TIMEOUT;
        res.held = HELD_OUT_W'(held_bytes);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_gap_pct);
  end

  // Compare each result transaction with the oldest expected session end
  always @(posedge clk_i) begin : check_results
    session_end_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (ends_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result tdata=%h", m_axis_tdata));
      end else begin
        want = ends_q.pop_front();
        if (m_axis_tdata[2:0] != want.answer || m_axis_tdata[10:3] != want.held ||
            m_axis_tdata[15:11] != '0) begin
          note_mismatch($sformatf("answer exp %0d got %0d, held exp %0d got %0d, pad %h",
                                  want.answer, m_axis_tdata[2:0], want.held,
                                  m_axis_tdata[10:3], m_axis_tdata[15:11]));
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one input transaction, then predict its effect
  task automatic send_item(input logic [1:0] op, input logic [7:0] rx);
    session_end_t res;
    while ($urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= rx;
    do @(posedge clk_i); while (!s_axis_tready);
    live_items++;
    if (step_session(op, rx, res)) ends_q.push_back(res);
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_item(OP_BYTE, text[i]);
  endtask

  // Drop valid and hold until every expected result is out and the pipeline is empty
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (ends_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [63:0] value);
    wait_quiet();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PATTERN_ONE:   pattern_cfg[0] = value;
      REG_PATTERN_TWO:   pattern_cfg[1] = value;
      REG_PATTERN_THREE: pattern_cfg[2] = value;
      REG_PATTERN_FOUR:  pattern_cfg[3] = value;
      REG_PATTERN_LENS:  lens_cfg = value[15:0];
      REG_TIMEOUT:       timeout_cfg = value[31:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Read a register and compare the bits it holds
  task automatic read_check(input reg_e idx);
    logic [63:0] want;
    logic [63:0] mask;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mask = '1;
    case (idx)
      REG_PATTERN_ONE:   want = pattern_cfg[0];
      REG_PATTERN_TWO:   want = pattern_cfg[1];
      REG_PATTERN_THREE: want = pattern_cfg[2];
      REG_PATTERN_FOUR:  want = pattern_cfg[3];
      REG_PATTERN_LENS:  begin
        want = 64'(lens_cfg);
        mask = 64'hFFFF;
      end
      default: begin
        want = 64'(timeout_cfg);
        mask = 64'hFFFF_FFFF;
      end
    endcase
    if ((prdata & mask) != want)
      note_mismatch($sformatf("register %0d read %h, expected %h", idx, prdata & mask, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly a small alphabet so random tails hit the patterns
  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 7))
      0: return 8'h41;
      1: return 8'h42;
      2: return CH_CR;
      3: return CH_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] rand_pattern();
    logic [63:0] pat;
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: begin
        for (int i = 0; i < PAT_CHARS; i++) pat[8*i +: 8] = rand_char();
        return pat;
      end
    endcase
  endfunction

  task automatic randomize_settings();
    logic [15:0] lens;
    for (int k = 0; k < NUM_PATTERNS; k++) write_reg(reg_e'(k), rand_pattern());
    for (int k = 0; k < NUM_PATTERNS; k++)
      lens[LEN_W*k +: LEN_W] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                           : 4'($urandom_range(1, 4));
    write_reg(REG_PATTERN_LENS, 64'(lens));
    case ($urandom_range(0, 15))
      0: write_reg(REG_TIMEOUT, 64'd0);
      1: write_reg(REG_TIMEOUT, 64'hFFFF_FFFF);
      default: write_reg(REG_TIMEOUT, 64'($urandom_range(1, 40)));
    endcase
  endtask

  // Reset values, extremes and readback of every register
  task automatic test_register_access();
    for (int i = 0; i <= REG_TIMEOUT; i++) read_check(reg_e'(i));
    write_reg(REG_PATTERN_ONE, '1);
    write_reg(REG_PATTERN_TWO, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_PATTERN_THREE, 64'h8000_0000_0000_0001);
    write_reg(REG_PATTERN_FOUR, '0);
    write_reg(REG_PATTERN_LENS, 64'hFFFF);
    write_reg(REG_TIMEOUT, 64'hFFFF_FFFF);
    for (int i = 0; i <= REG_TIMEOUT; i++) read_check(reg_e'(i));
    write_reg(REG_PATTERN_LENS, 64'd0);
    read_check(REG_PATTERN_LENS);
  endtask

  // Bytes, ticks and the unused op do nothing while idle
  task automatic test_idle_items();
    send_item(OP_BYTE, 8'h00);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_UNUSED, 8'hA5);
    send_item(OP_BYTE, 8'hFF);
  endtask

  // A zero timeout ends the session at start and leaves the block idle
  task automatic test_zero_timeout();
    write_reg(REG_TIMEOUT, 64'd0);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'h41);
    send_item(OP_TICK, 8'h00);
  endtask

  // Patterns one to three in turn, clamped length, and pattern one winning a tie with four
  task automatic test_pattern_priority();
    write_reg(REG_PATTERN_ONE, RESP_OK);
    write_reg(REG_PATTERN_TWO, '1);
    write_reg(REG_PATTERN_THREE, '0);
    write_reg(REG_PATTERN_FOUR, 64'hDEAD_BEEF_0000_000A);
    write_reg(REG_PATTERN_LENS, 64'h11F4);
    write_reg(REG_TIMEOUT, 64'hFFFF_FFFF);
    send_item(OP_START, 8'h00);
    send_text("xOK");
    send_item(OP_BYTE, CH_CR);
    send_item(OP_BYTE, CH_LF);
    send_item(OP_START, 8'h00);
    repeat (PAT_CHARS) send_item(OP_BYTE, 8'hFF);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'h00);
  endtask

  // A full-length zero pattern must not match the cleared history early
  task automatic test_short_history();
    write_reg(REG_PATTERN_TWO, '0);
    write_reg(REG_PATTERN_LENS, 64'h0080);
    send_item(OP_START, 8'h00);
    repeat (PAT_CHARS) send_item(OP_BYTE, 8'h00);
  endtask

  // Restart clears history and elapsed time; a later tick times out
  task automatic test_restart_and_timeout();
    write_reg(REG_PATTERN_ONE, RESP_OK);
    write_reg(REG_PATTERN_LENS, 64'h0004);
    write_reg(REG_TIMEOUT, 64'd3);
    send_item(OP_START, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_text("OK");
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, CH_CR);
    send_item(OP_BYTE, CH_LF);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_UNUSED, 8'h5A);
    send_item(OP_BYTE, 8'h41);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
  endtask

  // Lower the timeout and swap the pattern in the middle of a session
  task automatic test_live_reconfig();
    write_reg(REG_TIMEOUT, 64'd10);
    send_item(OP_START, 8'h00);
    repeat (4) send_item(OP_TICK, 8'h00);
    send_text("OK");
    write_reg(REG_TIMEOUT, 64'd2);
    send_item(OP_BYTE, CH_CR);
    write_reg(REG_PATTERN_ONE, 64'(CH_CR));
    write_reg(REG_PATTERN_LENS, 64'h0001);
    send_item(OP_BYTE, CH_LF);
    send_item(OP_TICK, 8'h00);
  endtask

  // Fill the buffer, then a matching byte is ignored and a tick reports 255 held
  task automatic test_buffer_full();
    write_reg(REG_PATTERN_LENS, 64'h0000);
    write_reg(REG_TIMEOUT, 64'hFFFF_FFFF);
    send_item(OP_START, 8'h00);
    repeat (HOLD_LIMIT + 1) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
    write_reg(REG_PATTERN_ONE, 64'h5A);
    write_reg(REG_PATTERN_LENS, 64'h0001);
    send_item(OP_BYTE, 8'h5A);
    write_reg(REG_TIMEOUT, 64'd1);
    send_item(OP_TICK, 8'h00);
  endtask

  // One body transaction of a random session: bytes, injected answers, ticks, noise
  task automatic send_session_item();
    int unsigned pick;
    int unsigned k;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      if (inject_q.size() == 0 && $urandom_range(0, 5) == 0) begin
        k = $urandom_range(0, NUM_PATTERNS - 1);
        len = 32'(lens_cfg[LEN_W*k +: LEN_W]);
        if (len > PAT_CHARS) len = PAT_CHARS;
        for (int i = 0; i < len; i++) inject_q.push_back(pattern_cfg[k][8*i +: 8]);
      end
      send_item(OP_BYTE, (inject_q.size() != 0) ? inject_q.pop_front() : rand_char());
    end else if (pick < 92) begin
      send_item(OP_TICK, 8'($urandom_range(0, 255)));
    end else if (pick < 96) begin
      send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
    end else begin
      inject_q.delete();
      send_item(OP_START, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_sessions(input int unsigned src_pct, input int unsigned sink_pct,
                                      input int unsigned count);
    int unsigned target;
    src_gap_pct  = src_pct;
    sink_gap_pct = sink_pct;
    target = live_items + count;
    while (live_items < target) begin
      if ($urandom_range(0, 3) == 0) randomize_settings();
      inject_q.delete();
      send_item(OP_START, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 40)) send_session_item();
    end
  endtask

  initial begin
    for (int k = 0; k < NUM_PATTERNS; k++) pattern_cfg[k] = '0;
    lens_cfg      = '0;
    timeout_cfg   = TIMEOUT_RESET;
    hist_bytes    = '0;
    held_bytes    = 0;
    ticks_seen    = '0;
    session_armed = 1'b0;
    live_items    = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    src_gap_pct   = 14;
    sink_gap_pct  = 56;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_idle_items();
    test_zero_timeout();
    test_pattern_priority();
    test_short_history();
    test_restart_and_timeout();
    test_live_reconfig();
    test_buffer_full();
    test_random_sessions(14, 56, PHASE_ITEMS);
    test_random_sessions(56, 14, PHASE_ITEMS);
    test_random_sessions(0, 0, PHASE_ITEMS);

    wait_quiet();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
